### src/shs_pkg.sv
// Shared types, command codes and constants for the half-step sequencer.
package shs_pkg;

    // Command codes carried in the command beat
    localparam logic [2:0] CMD_TICK     = 3'd0;
    localparam logic [2:0] CMD_COILS_OFF = 3'd1;
    localparam logic [2:0] CMD_COILS_ON = 3'd2;
    localparam logic [2:0] CMD_MOVE_CCW = 3'd3;
    localparam logic [2:0] CMD_MOVE_CW  = 3'd4;
    localparam logic [2:0] CMD_ARM      = 3'd5;
    localparam logic [2:0] CMD_DISARM   = 3'd6;

    // Configuration register indexes and reset values
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_PHASE    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_PERIOD = 1'd1;
    localparam logic [15:0] HALF_PHASE_RST    = 16'd2;
    localparam logic [15:0] REPEAT_PERIOD_RST = 16'd1000;

    // Default half-step count of one table pass
    localparam int TABLE_STEPS_DEF = 8;

    // angle*64/360 == (angle*DIV_RECIP) >> DIV_SHIFT for every 9-bit angle
    localparam int ANGLE_W = 9;
    localparam int DIV_RECIP_W = 12;
    localparam logic [DIV_RECIP_W-1:0] DIV_RECIP = 12'd2913;
    localparam int DIV_SHIFT = 14;
    localparam int PROD_W = ANGLE_W + DIV_RECIP_W;
    localparam int UNITS_W = PROD_W - DIV_SHIFT;
    localparam int PASSES_W = 10;

    // Counter-clockwise half-step patterns, before inversion
    localparam logic [3:0] CCW_TABLE [8] = '{
        4'h8, 4'hC, 4'h4, 4'h6, 4'h2, 4'h3, 4'h1, 4'h9
    };

    typedef struct packed {
        logic [2:0]         command;
        logic [ANGLE_W-1:0] angle;
    } t_cmd_beat;

    typedef struct packed {
        logic [3:0] coils;
        logic       busy_res;
        logic       rejected;
    } t_res_beat;

    // Coil drive for a table index; clockwise reads the table backwards
    function automatic logic [3:0] drive_for(input logic [2:0] idx, input logic ccw);
        logic [3:0] pat;
        pat = ccw ? CCW_TABLE[idx] : CCW_TABLE[~idx];
        return ~pat;
    endfunction

endpackage

### src/shs_stream_if.sv
// Valid/ready stream channel carrying one payload beat.
interface shs_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

### src/stepper_half_step_sequencer.sv
// Top level: half-step coil sequencer with tick, move and periodic-pass commands.
// Each accepted command beat's result beat is registered, valid in the next cycle.
// Throughput: one command beat per cycle; the result register refills in the
//   cycle it is taken, so the only stall is a result beat not yet taken.
// All per-beat work is a 9x12 constant multiply and 16-bit count/compare.
// Reset (synchronous, active low): coils off, idle, disarmed, registers at defaults.
module stepper_half_step_sequencer #(
    parameter int TABLE_STEPS = shs_pkg::TABLE_STEPS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [shs_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [shs_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    shs_stream_if.sink                      i_cmd,
    shs_stream_if.source                    o_res
);

    localparam int PW = $clog2(TABLE_STEPS);
    localparam logic [PW-1:0] POS_LAST = PW'(TABLE_STEPS - 1);

    // Configuration registers
    logic [15:0] r_half_phase;
    logic [15:0] r_repeat_period;

    // Sequencer state
    logic [3:0]                     r_coil, n_coil;
    logic [PW-1:0]                  r_pos, n_pos;
    logic [shs_pkg::PASSES_W-1:0]   r_passes, n_passes;
    logic                           r_gap, n_gap;
    logic [15:0]                    r_hold, n_hold;
    logic                           r_ccw, n_ccw;
    logic                           r_armed, n_armed;
    logic [15:0]                    r_period, n_period;
    logic                           r_running, n_running;

    // Result register
    logic                           r_out_valid;
    shs_pkg::t_res_beat             r_res;
    logic                           n_rej;

    logic                           accept;
    shs_pkg::t_cmd_beat             cmd;
    logic [shs_pkg::PROD_W-1:0]     prod;
    logic [shs_pkg::UNITS_W-1:0]    units;
    logic [shs_pkg::PASSES_W-1:0]   move_passes;
    logic [15:0]                    half_lim;
    logic [15:0]                    period_lim;
    logic [15:0]                    hold_inc;
    logic [15:0]                    period_inc;
    logic [shs_pkg::PASSES_W-1:0]   passes_dec;
    logic [PW-1:0]                  pos_inc;
    logic [PW+2:0]                  pos_ext;

    assign cmd = i_cmd.payload;
    assign i_cmd.ready = !r_out_valid || o_res.ready;
    assign accept = i_cmd.valid && i_cmd.ready;

    // Passes of a move: (angle*64/360)*8, by reciprocal multiply
    assign prod = shs_pkg::PROD_W'(cmd.angle) * shs_pkg::PROD_W'(shs_pkg::DIV_RECIP);
    assign units = prod[shs_pkg::PROD_W-1:shs_pkg::DIV_SHIFT];
    assign move_passes = {units[shs_pkg::PASSES_W-4:0], 3'b000};

    // A zero register acts as one
    assign half_lim = (r_half_phase == 16'd0) ? 16'd1 : r_half_phase;
    assign period_lim = (r_repeat_period == 16'd0) ? 16'd1 : r_repeat_period;
    assign hold_inc = r_hold + 16'd1;
    assign period_inc = r_period + 16'd1;
    assign passes_dec = (r_passes != '0) ? r_passes - 1'b1 : r_passes;
    assign pos_inc = r_pos + 1'b1;
    assign pos_ext = {3'b000, pos_inc};

    // Next state and result for one command beat
    always_comb begin
        n_coil    = r_coil;
        n_pos     = r_pos;
        n_passes  = r_passes;
        n_gap     = r_gap;
        n_hold    = r_hold;
        n_ccw     = r_ccw;
        n_armed   = r_armed;
        n_period  = r_period;
        n_running = r_running;
        n_rej     = 1'b0;
        if (cmd.command == shs_pkg::CMD_TICK) begin
            if (r_running) begin
                if (hold_inc < half_lim) begin
                    n_hold = hold_inc;
                end else begin
                    n_hold = '0;
                    if (!r_gap) begin
                        n_gap  = 1'b1;
                        n_coil = '0;
                    end else begin
                        n_gap = 1'b0;
                        if (r_pos == POS_LAST) begin
                            n_pos    = '0;
                            n_passes = passes_dec;
                            if (passes_dec == '0) begin
                                n_running = 1'b0;
                                n_coil    = '0;
                            end else begin
                                n_coil = shs_pkg::drive_for(3'd0, r_ccw);
                            end
                        end else begin
                            n_pos  = pos_inc;
                            n_coil = shs_pkg::drive_for(pos_ext[2:0], r_ccw);
                        end
                    end
                end
            end else if (r_armed) begin
                if (period_inc >= period_lim) begin
                    // Start one clockwise pass
                    n_period  = '0;
                    n_running = 1'b1;
                    n_passes  = shs_pkg::PASSES_W'(1);
                    n_ccw     = 1'b0;
                    n_pos     = '0;
                    n_gap     = 1'b0;
                    n_hold    = '0;
                    n_coil    = shs_pkg::drive_for(3'd0, 1'b0);
                end else begin
                    n_period = period_inc;
                end
            end
        end else if (cmd.command <= shs_pkg::CMD_DISARM) begin
            if (r_running) begin
                n_rej = 1'b1;
            end else begin
                unique case (cmd.command) inside
                    shs_pkg::CMD_COILS_OFF: begin
                        n_coil = '0;
                    end
                    shs_pkg::CMD_COILS_ON: begin
                        n_coil = 4'hF;
                    end
                    shs_pkg::CMD_MOVE_CCW, shs_pkg::CMD_MOVE_CW: begin
                        if (units != '0) begin
                            n_running = 1'b1;
                            n_passes  = move_passes;
                            n_ccw     = (cmd.command == shs_pkg::CMD_MOVE_CCW);
                            n_pos     = '0;
                            n_gap     = 1'b0;
                            n_hold    = '0;
                            n_coil    = shs_pkg::drive_for(3'd0,
                                            cmd.command == shs_pkg::CMD_MOVE_CCW);
                        end
                    end
                    shs_pkg::CMD_ARM: begin
                        n_armed  = 1'b1;
                        n_period = '0;
                    end
                    default: begin
                        n_armed  = 1'b0;
                        n_period = '0;
                    end
                endcase
            end
        end
    end

    // Hold configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_phase    <= shs_pkg::HALF_PHASE_RST;
            r_repeat_period <= shs_pkg::REPEAT_PERIOD_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == shs_pkg::CFG_HALF_PHASE) begin
                r_half_phase <= i_cfg_data;
            end else if (i_cfg_idx == shs_pkg::CFG_REPEAT_PERIOD) begin
                r_repeat_period <= i_cfg_data;
            end
        end
    end

    // Advance sequencer state on each accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coil    <= '0;
            r_pos     <= '0;
            r_passes  <= '0;
            r_gap     <= 1'b0;
            r_hold    <= '0;
            r_ccw     <= 1'b0;
            r_armed   <= 1'b0;
            r_period  <= '0;
            r_running <= 1'b0;
        end else if (accept) begin
            r_coil    <= n_coil;
            r_pos     <= n_pos;
            r_passes  <= n_passes;
            r_gap     <= n_gap;
            r_hold    <= n_hold;
            r_ccw     <= n_ccw;
            r_armed   <= n_armed;
            r_period  <= n_period;
            r_running <= n_running;
        end
    end

    // Result register: load on accept, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res.coils    <= n_coil;
            r_res.busy_res <= n_running;
            r_res.rejected <= n_rej;
        end
    end

    assign o_res.valid = r_out_valid;
    assign o_res.payload = r_res;

`ifndef ASSERT_OFF
    // A running sequence always has passes left
    a_run_passes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_running |-> (r_passes != '0))
        else $error("running with no passes left");

    // Coils are off during the gap phase
    a_gap_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gap |-> (r_coil == 4'h0))
        else $error("coils driven during gap phase");

    // Idle leaves the step timer cleared
    a_idle_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_running |-> (!r_gap && r_hold == 16'd0))
        else $error("step timer not cleared while idle");
`endif

endmodule
